// ----- sv/cfr_pkg.sv -----
`default_nettype none

package cfr_pkg;

    // Field widths of the request and result streams
    localparam int REQ_W      = 2;
    localparam int IDX_W      = 6;
    localparam int PAGE_W     = 36;
    localparam int POOL_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    // Defaults
    localparam int FRAMES_DEF      = 64;
    localparam int POOL_RESET_INT  = 64;
    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(POOL_RESET_INT);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_UNPIN   = 2'd1,
        REQ_ACCESS  = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 2'd0,
        STS_ALL_PINNED = 2'd1,
        STS_BAD_FRAME  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SWEEP_RD,
        S_SWEEP_EV,
        S_OP_RD,
        S_OP_EV,
        S_DONE
    } t_state;

    // Per-frame bookkeeping held in the flag memory
    typedef struct packed {
        logic used;
        logic pinned;
        logic accessed;
    } t_flags;

    typedef struct packed {
        t_status             status;
        logic                evicted;
        logic [PAGE_W-1:0]   page;
        logic [IDX_W-1:0]    frame;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/cfr_flag_store.sv -----
`default_nettype none

module cfr_flag_store #(
    parameter int FRAMES = cfr_pkg::FRAMES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [$clog2(FRAMES)-1:0] i_rd_addr,
    output cfr_pkg::t_flags             o_rd_data,
    input  wire logic                   i_we,
    input  wire logic [$clog2(FRAMES)-1:0] i_wr_addr,
    input  cfr_pkg::t_flags             i_wr_data,
    output logic                        o_busy
);

    localparam int FW = $clog2(FRAMES);

    cfr_pkg::t_flags r_mem [FRAMES];
    cfr_pkg::t_flags r_rd_data;
    logic            r_clr_busy;
    logic [FW-1:0]   r_clr_addr;

    logic            w_we;
    logic [FW-1:0]   w_addr;
    cfr_pkg::t_flags w_data;

    // Clearing pass takes the write port after reset
    always_comb begin
        w_we   = r_clr_busy | i_we;
        w_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        w_data = r_clr_busy ? cfr_pkg::t_flags'('0) : i_wr_data;
    end

    // Sweep every entry to zero, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + FW'(1);
            if (r_clr_addr == FW'(FRAMES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

// ----- sv/cfr_page_store.sv -----
`default_nettype none

module cfr_page_store #(
    parameter int FRAMES = cfr_pkg::FRAMES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic [$clog2(FRAMES)-1:0]   i_rd_addr,
    output logic [cfr_pkg::PAGE_W-1:0]       o_rd_data,
    input  wire logic                        i_we,
    input  wire logic [$clog2(FRAMES)-1:0]   i_wr_addr,
    input  wire logic [cfr_pkg::PAGE_W-1:0]  i_wr_data
);

    logic [cfr_pkg::PAGE_W-1:0] r_mem [FRAMES];
    logic [cfr_pkg::PAGE_W-1:0] r_rd_data;

    // Page numbers per frame, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/cfr_engine.sv -----
`default_nettype none

module cfr_engine #(
    parameter int FRAMES = cfr_pkg::FRAMES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [((cfr_pkg::POOL_W > $clog2(FRAMES + 1)) ?
                        cfr_pkg::POOL_W : $clog2(FRAMES + 1))-1:0] i_pool,
    input  wire logic                        i_busy,
    // Request side
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [cfr_pkg::REQ_W-1:0]   i_req,
    input  wire logic [cfr_pkg::IDX_W-1:0]   i_idx,
    input  wire logic [cfr_pkg::PAGE_W-1:0]  i_page,
    // Flag memory
    output logic [$clog2(FRAMES)-1:0]        o_addr,
    input  cfr_pkg::t_flags                  i_flags,
    output logic                             o_flag_we,
    output cfr_pkg::t_flags                  o_flag_wd,
    // Page memory
    input  wire logic [cfr_pkg::PAGE_W-1:0]  i_page_rd,
    output logic                             o_page_we,
    output logic [cfr_pkg::PAGE_W-1:0]       o_page_wd,
    // Result side
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output cfr_pkg::t_result                 o_res
);

    localparam int FW = $clog2(FRAMES);
    localparam int CW = (cfr_pkg::POOL_W > $clog2(FRAMES + 1)) ?
                        cfr_pkg::POOL_W : $clog2(FRAMES + 1);
    localparam int HAND_RST = ((cfr_pkg::POOL_RESET_INT < FRAMES) ?
                               cfr_pkg::POOL_RESET_INT : FRAMES) - 1;

    cfr_pkg::t_state  r_state, n_state;
    cfr_pkg::t_req    r_req, n_req;
    logic [cfr_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [cfr_pkg::PAGE_W-1:0] r_page, n_page;
    logic [FW-1:0]    r_pos, n_pos;
    logic [FW-1:0]    r_hand, n_hand;
    logic             r_any, n_any;
    cfr_pkg::t_result r_res, n_res;
    cfr_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic [FW-1:0]    w_next_pos;
    logic [FW-1:0]    w_next_hand;
    logic             w_any;
    logic             w_scan_last;

    // Advance a frame position with wraparound at the pool end
    function automatic logic [FW-1:0] f_advance(input logic [FW-1:0] pos,
                                                input logic [CW-1:0] pool);
        logic [CW-1:0] sum;
        sum = CW'(pos) + CW'(1);
        if (sum >= pool) begin
            return '0;
        end
        return FW'(sum);
    endfunction

    always_comb begin
        w_next_pos  = f_advance(r_pos, i_pool);
        w_next_hand = f_advance(r_hand, i_pool);
        w_any       = r_any | ~i_flags.pinned;
        w_scan_last = (CW'(r_pos) + CW'(1)) >= i_pool;
    end

    // Both memories are addressed by the current position
    assign o_addr    = r_pos;
    assign o_page_wd = r_page;

    // Next state and memory writes
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_page      = r_page;
        n_pos       = r_pos;
        n_hand      = r_hand;
        n_any       = r_any;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_res_ready;
        o_in_ready  = 1'b0;
        o_flag_we   = 1'b0;
        o_flag_wd   = '0;
        o_page_we   = 1'b0;

        case (r_state)
            cfr_pkg::S_IDLE: begin
                o_in_ready = ~i_busy;
                if (i_in_valid && !i_busy) begin
                    n_req  = cfr_pkg::t_req'(i_req);
                    n_idx  = i_idx;
                    n_page = i_page;
                    n_any  = 1'b0;
                    if (cfr_pkg::t_req'(i_req) == cfr_pkg::REQ_ALLOC) begin
                        n_pos   = '0;
                        n_state = cfr_pkg::S_SCAN_RD;
                    end else if (CW'(i_idx) >= i_pool) begin
                        n_res   = '{status: cfr_pkg::STS_BAD_FRAME, evicted: 1'b0,
                                    page: '0, frame: i_idx};
                        n_state = cfr_pkg::S_DONE;
                    end else begin
                        n_pos   = FW'(i_idx);
                        n_state = cfr_pkg::S_OP_RD;
                    end
                end
            end

            cfr_pkg::S_SCAN_RD: begin
                n_state = cfr_pkg::S_SCAN_EV;
            end

            // Take the lowest free frame, else note any unpinned one
            cfr_pkg::S_SCAN_EV: begin
                if (!i_flags.used) begin
                    o_flag_we = 1'b1;
                    o_flag_wd = '{used: 1'b1, pinned: 1'b1, accessed: 1'b0};
                    o_page_we = 1'b1;
                    n_res     = '{status: cfr_pkg::STS_OK, evicted: 1'b0, page: '0,
                                  frame: cfr_pkg::IDX_W'(r_pos)};
                    n_state   = cfr_pkg::S_DONE;
                end else begin
                    n_any = w_any;
                    if (w_scan_last) begin
                        if (w_any) begin
                            n_pos   = w_next_hand;
                            n_state = cfr_pkg::S_SWEEP_RD;
                        end else begin
                            n_res   = '{status: cfr_pkg::STS_ALL_PINNED, evicted: 1'b0,
                                        page: '0, frame: '0};
                            n_state = cfr_pkg::S_DONE;
                        end
                    end else begin
                        n_pos   = r_pos + FW'(1);
                        n_state = cfr_pkg::S_SCAN_RD;
                    end
                end
            end

            cfr_pkg::S_SWEEP_RD: begin
                n_state = cfr_pkg::S_SWEEP_EV;
            end

            // Skip pinned frames, give a second chance to accessed ones
            cfr_pkg::S_SWEEP_EV: begin
                n_hand = r_pos;
                if (i_flags.pinned) begin
                    n_pos   = w_next_pos;
                    n_state = cfr_pkg::S_SWEEP_RD;
                end else if (i_flags.accessed) begin
                    o_flag_we = 1'b1;
                    o_flag_wd = '{used: 1'b1, pinned: 1'b0, accessed: 1'b0};
                    n_pos     = w_next_pos;
                    n_state   = cfr_pkg::S_SWEEP_RD;
                end else begin
                    o_flag_we = 1'b1;
                    o_flag_wd = '{used: 1'b1, pinned: 1'b1, accessed: 1'b0};
                    o_page_we = 1'b1;
                    n_res     = '{status: cfr_pkg::STS_OK, evicted: 1'b1,
                                  page: i_page_rd, frame: cfr_pkg::IDX_W'(r_pos)};
                    n_state   = cfr_pkg::S_DONE;
                end
            end

            cfr_pkg::S_OP_RD: begin
                n_state = cfr_pkg::S_OP_EV;
            end

            // Unpin, mark accessed or release a frame in use
            cfr_pkg::S_OP_EV: begin
                if (!i_flags.used) begin
                    n_res = '{status: cfr_pkg::STS_BAD_FRAME, evicted: 1'b0,
                              page: '0, frame: r_idx};
                end else begin
                    o_flag_we = 1'b1;
                    case (r_req)
                        cfr_pkg::REQ_UNPIN: begin
                            o_flag_wd = '{used: 1'b1, pinned: 1'b0,
                                          accessed: i_flags.accessed};
                        end
                        cfr_pkg::REQ_ACCESS: begin
                            o_flag_wd = '{used: 1'b1, pinned: i_flags.pinned,
                                          accessed: 1'b1};
                        end
                        default: begin
                            o_flag_wd = '0;
                        end
                    endcase
                    n_res = '{status: cfr_pkg::STS_OK, evicted: 1'b0,
                              page: '0, frame: r_idx};
                end
                n_state = cfr_pkg::S_DONE;
            end

            // Hold the result until the output register is free
            cfr_pkg::S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = cfr_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfr_pkg::S_IDLE;
            r_hand      <= FW'(HAND_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hand      <= n_hand;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_page <= n_page;
        r_pos  <= n_pos;
        r_any  <= n_any;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_scan_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfr_pkg::S_SCAN_RD) |-> (CW'(r_pos) < i_pool))
        else $error("free-frame scan left the pool");

    a_sweep_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfr_pkg::S_SWEEP_RD) |-> (CW'(r_pos) < i_pool))
        else $error("clock hand left the pool");

    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_busy |-> (r_state == cfr_pkg::S_IDLE && !o_in_ready))
        else $error("request taken during flag clearing");

    a_evict_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfr_pkg::S_DONE && r_res.evicted) |->
        (r_req == cfr_pkg::REQ_ALLOC && r_res.status == cfr_pkg::STS_OK))
        else $error("eviction reported outside a successful allocate");
`endif

endmodule

`default_nettype wire

// ----- sv/clock_frame_replacement.sv -----
// Unpin, mark accessed, release: states OP_RD, OP_EV and DONE, then the output register; a frame
// outside the pool goes straight to DONE. The next request is taken once the engine is back in idle.
// Allocate: a SCAN_RD/SCAN_EV pair per frame read by the free-frame scan, then a SWEEP_RD/SWEEP_EV
// pair per frame stepped by the clock hand (at most two laps), then DONE and the output register.
// Reset: synchronous, active low; then a clearing pass zeroes the flag memory with
// s_axis_tready low. Page numbers are not cleared.
`default_nettype none

module clock_frame_replacement #(
    parameter int FRAMES = cfr_pkg::FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration: pool_frames
    input  wire logic                          i_cfg_we,
    input  wire logic [cfr_pkg::POOL_W-1:0]    i_cfg_wdata,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [cfr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // frame_index[5:0], page_number[41:6]
    input  wire logic [cfr_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type[1:0]
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [cfr_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // frame_out[5:0], evicted[6],
                                                              // evicted_page[42:7]
    output logic [cfr_pkg::STATUS_W-1:0]       m_axis_tuser   // status[1:0]
);

    localparam int FW = $clog2(FRAMES);
    localparam int CW = (cfr_pkg::POOL_W > $clog2(FRAMES + 1)) ?
                        cfr_pkg::POOL_W : $clog2(FRAMES + 1);
    localparam int PAD_W = cfr_pkg::M_TDATA_W - cfr_pkg::IDX_W - 1 - cfr_pkg::PAGE_W;

    logic [cfr_pkg::POOL_W-1:0] r_pool_cfg;
    logic [CW-1:0]              w_pool;

    logic [FW-1:0]              w_addr;
    cfr_pkg::t_flags            w_flags_rd;
    logic                       w_flag_we;
    cfr_pkg::t_flags            w_flag_wd;
    logic                       w_busy;
    logic [cfr_pkg::PAGE_W-1:0] w_page_rd;
    logic                       w_page_we;
    logic [cfr_pkg::PAGE_W-1:0] w_page_wd;
    cfr_pkg::t_result           w_res;

    // Pool size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_cfg <= cfr_pkg::POOL_RESET;
        end else if (i_cfg_we) begin
            r_pool_cfg <= i_cfg_wdata;
        end
    end

    // Clamp the pool to 1..FRAMES
    always_comb begin
        w_pool = CW'(r_pool_cfg);
        if (r_pool_cfg == '0) begin
            w_pool = CW'(1);
        end else if (CW'(r_pool_cfg) > CW'(FRAMES)) begin
            w_pool = CW'(FRAMES);
        end
    end

    cfr_flag_store #(.FRAMES(FRAMES)) u_flags (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_addr),
        .o_rd_data (w_flags_rd),
        .i_we      (w_flag_we),
        .i_wr_addr (w_addr),
        .i_wr_data (w_flag_wd),
        .o_busy    (w_busy)
    );

    cfr_page_store #(.FRAMES(FRAMES)) u_pages (
        .i_clk     (i_clk),
        .i_rd_addr (w_addr),
        .o_rd_data (w_page_rd),
        .i_we      (w_page_we),
        .i_wr_addr (w_addr),
        .i_wr_data (w_page_wd)
    );

    cfr_engine #(.FRAMES(FRAMES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool      (w_pool),
        .i_busy      (w_busy),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (s_axis_tuser),
        .i_idx       (s_axis_tdata[cfr_pkg::IDX_W-1:0]),
        .i_page      (s_axis_tdata[cfr_pkg::IDX_W +: cfr_pkg::PAGE_W]),
        .o_addr      (w_addr),
        .i_flags     (w_flags_rd),
        .o_flag_we   (w_flag_we),
        .o_flag_wd   (w_flag_wd),
        .i_page_rd   (w_page_rd),
        .o_page_we   (w_page_we),
        .o_page_wd   (w_page_wd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // Pack the result
    assign m_axis_tdata = {{PAD_W{1'b0}}, w_res.page, w_res.evicted, w_res.frame};
    assign m_axis_tuser = w_res.status;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;

    localparam int FRAMES       = cfr_pkg::FRAMES_DEF;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int MAX_GAP      = 17;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [cfr_pkg::POOL_W-1:0]      i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [cfr_pkg::S_TDATA_W-1:0]   s_axis_tdata;   // frame_index[5:0], page_number[41:6]
    logic [cfr_pkg::REQ_W-1:0]       s_axis_tuser;   // req_type[1:0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [cfr_pkg::M_TDATA_W-1:0]   m_axis_tdata;   // frame_out[5:0], evicted[6],
                                                     // evicted_page[42:7]
    logic [cfr_pkg::STATUS_W-1:0]    m_axis_tuser;   // status[1:0]

    // Shadow frame table
    bit                              slot_used [FRAMES];
    bit                              slot_pinned [FRAMES];
    bit                              slot_referenced [FRAMES];
    logic [cfr_pkg::PAGE_W-1:0]      slot_page [FRAMES];
    int                              hand_pos;
    logic [cfr_pkg::POOL_W-1:0]      pool_frames_reg;

    cfr_pkg::t_result                outcome_q [$];
    int                              mismatches;
    int unsigned                     cycle_count;
    bit                              feed_gaps;
    bit                              drain_gaps;
    int                              sink_hold;

    clock_frame_replacement #(
        .FRAMES (FRAMES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Pool size as the block sees it: 0 acts as 1, anything above FRAMES as FRAMES
    function automatic int active_pool();
        if (pool_frames_reg == 0)
            return 1;
        if (pool_frames_reg > FRAMES)
            return FRAMES;
        return int'(pool_frames_reg);
    endfunction

    function automatic void take_frame(int f, logic [cfr_pkg::PAGE_W-1:0] page);
        slot_used[f]       = 1'b1;
        slot_pinned[f]     = 1'b1;
        slot_referenced[f] = 1'b0;
        slot_page[f]       = page;
    endfunction

    // Apply one request to the shadow table and return the result it must produce
    function automatic cfr_pkg::t_result serve_request(cfr_pkg::t_req req,
                                                       logic [cfr_pkg::IDX_W-1:0] idx,
                                                       logic [cfr_pkg::PAGE_W-1:0] page);
        cfr_pkg::t_result r;
        int      pool;
        int      h;
        bit      any_loose;
        r        = '0;
        r.status = cfr_pkg::STS_OK;
        pool     = active_pool();
        if (req == cfr_pkg::REQ_ALLOC) begin
            // Lowest free frame first
            for (int f = 0; f < pool; f++) begin
                if (!slot_used[f]) begin
                    take_frame(f, page);
                    r.frame = cfr_pkg::IDX_W'(f);
                    return r;
                end
            end
            any_loose = 1'b0;
            for (int f = 0; f < pool; f++)
                if (!slot_pinned[f])
                    any_loose = 1'b1;
            if (!any_loose) begin
                r.status = cfr_pkg::STS_ALL_PINNED;
                return r;
            end
            // Sweep the hand: skip pinned, give referenced frames a second chance
            forever begin
                h = hand_pos + 1;
                if (h >= pool)
                    h = 0;
                hand_pos = h;
                if (slot_pinned[h])
                    continue;
                if (slot_referenced[h]) begin
                    slot_referenced[h] = 1'b0;
                    continue;
                end
                r.frame   = cfr_pkg::IDX_W'(h);
                r.evicted = 1'b1;
                r.page    = slot_page[h];
                take_frame(h, page);
                return r;
            end
        end
        r.frame = idx;
        if (int'(idx) >= pool || !slot_used[idx]) begin
            r.status = cfr_pkg::STS_BAD_FRAME;
            return r;
        end
        case (req)
            cfr_pkg::REQ_UNPIN: begin
                slot_pinned[idx] = 1'b0;
            end
            cfr_pkg::REQ_ACCESS: begin
                slot_referenced[idx] = 1'b1;
            end
            default: begin
                slot_used[idx]       = 1'b0;
                slot_pinned[idx]     = 1'b0;
                slot_referenced[idx] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Offer one request; called at a falling edge, returns at a falling edge
    task automatic send_request(input cfr_pkg::t_req req,
                                input logic [cfr_pkg::IDX_W-1:0] idx,
                                input logic [cfr_pkg::PAGE_W-1:0] page,
                                output cfr_pkg::t_result predicted);
        int gap;
        gap = feed_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {{(cfr_pkg::S_TDATA_W - cfr_pkg::PAGE_W - cfr_pkg::IDX_W){1'b0}},
                          page, idx};
        s_axis_tuser  <= req;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = serve_request(req, idx, page);
        outcome_q.push_back(predicted);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every outstanding request has answered
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_pool(input logic [cfr_pkg::POOL_W-1:0] frames);
        settle();
        i_cfg_wdata <= frames;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we        <= 1'b0;
        pool_frames_reg = frames;
        @(negedge i_clk);
    endtask

    // Result sink: random hold-offs, plus a long hold when one is requested
    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                gap       = sink_hold;
                sink_hold = 0;
            end else begin
                gap = drain_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        cfr_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual frame %0d status %0d", $time,
                         m_axis_tdata[cfr_pkg::IDX_W-1:0], m_axis_tuser);
            end else begin
                want = outcome_q.pop_front();
                if (m_axis_tdata[cfr_pkg::IDX_W-1:0] !== want.frame) begin
                    mismatches++;
                    $display("%0t: frame_out expected %0d actual %0d", $time,
                             want.frame, m_axis_tdata[cfr_pkg::IDX_W-1:0]);
                end
                if (m_axis_tdata[cfr_pkg::IDX_W] !== want.evicted) begin
                    mismatches++;
                    $display("%0t: evicted expected %0d actual %0d", $time,
                             want.evicted, m_axis_tdata[cfr_pkg::IDX_W]);
                end
                if (m_axis_tdata[cfr_pkg::IDX_W+cfr_pkg::PAGE_W:cfr_pkg::IDX_W+1]
                        !== want.page) begin
                    mismatches++;
                    $display("%0t: evicted_page expected %h actual %h", $time,
                             want.page,
                             m_axis_tdata[cfr_pkg::IDX_W+cfr_pkg::PAGE_W:cfr_pkg::IDX_W+1]);
                end
                if (m_axis_tuser !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                end
            end
        end
    end

    // Reset pool of 64: frame out of use, plain grant, unpin and release
    task automatic test_reset_defaults();
        cfr_pkg::t_result got;
        send_request(cfr_pkg::REQ_ACCESS, 6'd63, '0, got);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, '0, got);
        send_request(cfr_pkg::REQ_UNPIN, 6'd0, '0, got);
        send_request(cfr_pkg::REQ_RELEASE, 6'd0, '0, got);
        send_request(cfr_pkg::REQ_RELEASE, 6'd0, '0, got);
    endtask

    // Two frames: all pinned, second chance, wrap of a hand left outside the pool
    task automatic test_clock_sweep();
        cfr_pkg::t_result got;
        set_pool(7'd2);
        send_request(cfr_pkg::REQ_ALLOC, 6'd63, '1, got);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, 36'h5_A5A5_A5A5, got);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, 36'h0_0000_0001, got);
        send_request(cfr_pkg::REQ_UNPIN, 6'd0, '0, got);
        send_request(cfr_pkg::REQ_UNPIN, 6'd1, '0, got);
        send_request(cfr_pkg::REQ_ACCESS, 6'd0, '0, got);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, 36'h8_0000_0000, got);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, 36'h1_2345_6789, got);
        send_request(cfr_pkg::REQ_UNPIN, 6'd5, '0, got);
        send_request(cfr_pkg::REQ_ACCESS, 6'd63, '0, got);
        send_request(cfr_pkg::REQ_RELEASE, 6'd1, '0, got);
    endtask

    // Pool register below and above its range
    task automatic test_pool_limits();
        cfr_pkg::t_result got;
        set_pool(7'd0);
        send_request(cfr_pkg::REQ_RELEASE, 6'd1, '0, got);
        send_request(cfr_pkg::REQ_UNPIN, 6'd0, '0, got);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, 36'hF_0F0F_0F0F, got);
        set_pool(7'd127);
        send_request(cfr_pkg::REQ_ALLOC, 6'd0, 36'h0_F0F0_F0F0, got);
        send_request(cfr_pkg::REQ_ACCESS, 6'd2, '0, got);
    endtask

    // Random allocate, unpin, access and release traffic, mostly on frames in use, with some noise
    task automatic test_random_traffic();
        logic [cfr_pkg::POOL_W-1:0] pool_plan [8];
        cfr_pkg::t_result           got;
        cfr_pkg::t_req              req;
        logic [cfr_pkg::IDX_W-1:0]  idx;
        logic [63:0]                r;
        int                         roll;
        int                         live;
        int                         pick;
        pool_plan = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd16, 7'd0, 7'd96, 7'd3};
        pool_plan[7] = cfr_pkg::POOL_W'($urandom_range(2, 12));
        foreach (pool_plan[p]) begin
            set_pool(pool_plan[p]);
            feed_gaps  = ($urandom_range(0, 3) != 0);
            drain_gaps = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 160; n++) begin
                roll = $urandom_range(0, 99);
                r    = {$urandom(), $urandom()};
                if (roll < 30) begin
                    send_request(cfr_pkg::REQ_ALLOC, r[41:36], r[35:0], got);
                    // complete the claim on the granted frame
                    if (got.status == cfr_pkg::STS_OK && $urandom_range(0, 2) != 0)
                        send_request(cfr_pkg::REQ_UNPIN, got.frame, r[63:28], got);
                end else if (roll < 90) begin
                    req = (roll < 55) ? cfr_pkg::REQ_UNPIN :
                          (roll < 75) ? cfr_pkg::REQ_ACCESS : cfr_pkg::REQ_RELEASE;
                    idx = r[41:36];
                    // aim at a frame in use most of the time
                    if ($urandom_range(0, 5) != 0) begin
                        live = 0;
                        for (int f = 0; f < active_pool(); f++)
                            if (slot_used[f])
                                live++;
                        if (live > 0) begin
                            pick = $urandom_range(0, live - 1);
                            for (int f = 0; f < active_pool(); f++) begin
                                if (slot_used[f]) begin
                                    if (pick == 0)
                                        idx = cfr_pkg::IDX_W'(f);
                                    pick--;
                                end
                            end
                        end
                    end
                    send_request(req, idx, r[35:0], got);
                end else begin
                    send_request(cfr_pkg::t_req'(r[43:42]), r[41:36], r[35:0], got);
                end
                // alternate idle and back-to-back stretches
                if (n % 40 == 39) begin
                    feed_gaps  = ~feed_gaps;
                    drain_gaps = $urandom_range(0, 1);
                end
            end
        end
    endtask

    // Hold the result side for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        cfr_pkg::t_result got;
        logic [63:0]      r;
        set_pool(7'd4);
        feed_gaps  = 1'b0;
        drain_gaps = 1'b0;
        sink_hold  = 400;
        for (int n = 0; n < 40; n++) begin
            r = {$urandom(), $urandom()};
            send_request(cfr_pkg::t_req'(r[43:42]), cfr_pkg::IDX_W'(r[37:36]), r[35:0], got);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = cfr_pkg::REQ_ALLOC;
        mismatches      = 0;
        cycle_count     = 0;
        feed_gaps       = 1'b1;
        drain_gaps      = 1'b1;
        sink_hold       = 0;
        pool_frames_reg = cfr_pkg::POOL_RESET;
        hand_pos        = active_pool() - 1;
        foreach (slot_page[f])
            slot_page[f] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_clock_sweep();
        test_pool_limits();
        test_random_traffic();
        test_result_backpressure();

        // Let any stray result show up before judging
        settle();
        repeat (400) @(negedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
